[sv/ubx_frame_receiver_assert.svh]
// assertion macros for the ubx frame receiver
// expects signals named clock and reset in the module that uses them
`ifndef UBX_FRAME_RECEIVER_ASSERT_SVH
`define UBX_FRAME_RECEIVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// property that must hold at every edge outside reset
`define UBX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// expression that must never be true outside reset
`define UBX_ASSERT_NEVER(lbl, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);
`else
`define UBX_ASSERT(lbl, prop, msg)
`define UBX_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

[sv/ubxr_pkg.sv]
// shared types and constants for the ubx frame receiver
// no dependencies
package ubxr_pkg;

   localparam int unsigned BYTE_W         = 8;
   localparam int unsigned ADDR_W         = 9;
   localparam int unsigned LEN_W          = 16;
   localparam int unsigned BUFFER_LEN_DEF = 512;

   localparam logic [BYTE_W-1:0] SYNC_CHAR_1 = 8'hB5;
   localparam logic [BYTE_W-1:0] SYNC_CHAR_2 = 8'h62;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'd0,
      PH_SYNC    = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LEN_LO  = 4'd4,
      PH_LEN_HI  = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CK_A    = 4'd7,
      PH_CK_B    = 4'd8
   } phase_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              frame_done;
      logic              frame_dropped;
   } rsp_payload_type;

endpackage

[sv/ubxr_stream_if.sv]
// valid/ready channels of the ubx frame receiver
// depends on ubxr_pkg
interface ubxr_req_if;
   logic                        valid;
   logic                        ready;
   logic [ubxr_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        wr_en;
   logic [ubxr_pkg::ADDR_W-1:0] wr_addr;
   logic [ubxr_pkg::BYTE_W-1:0] wr_data;
   logic                        frame_done;
   logic                        frame_dropped;

   modport source (output valid, output wr_en, output wr_addr, output wr_data,
                   output frame_done, output frame_dropped, input ready);
   modport sink   (input valid, input wr_en, input wr_addr, input wr_data,
                   input frame_done, input frame_dropped, output ready);
endinterface

[sv/ubxr_parser.sv]
// frame parse state, fletcher-8 sums and buffer write index
// depends on ubxr_pkg and ubx_frame_receiver_assert.svh
`include "ubx_frame_receiver_assert.svh"

module ubxr_parser #(
   parameter int unsigned BUFFER_LEN = ubxr_pkg::BUFFER_LEN_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic [ubxr_pkg::BYTE_W-1:0]     rx_byte,
   output ubxr_pkg::rsp_payload_type       result
);

   localparam int unsigned IDX_W  = $clog2(BUFFER_LEN + 1);
   localparam int unsigned BYTE_W = ubxr_pkg::BYTE_W;
   localparam int unsigned LEN_W  = ubxr_pkg::LEN_W;
   localparam int unsigned ADDR_W = ubxr_pkg::ADDR_W;

   ubxr_pkg::phase_type phase_ff, phase_in;
   logic [LEN_W-1:0]    bytes_left_ff, bytes_left_in;
   logic [BYTE_W-1:0]   sum_a_ff, sum_a_in;
   logic [BYTE_W-1:0]   sum_b_ff, sum_b_in;
   logic [IDX_W-1:0]    write_index_ff, write_index_in;

   logic                store;
   logic                done;
   logic                dropped;
   logic                wr_en;
   logic [LEN_W-1:0]    len_full;
   logic [LEN_W-1:0]    bytes_dec;
   logic [BYTE_W-1:0]   base_a;
   logic [BYTE_W-1:0]   base_b;
   logic [BYTE_W-1:0]   sum_a_new;
   logic [BYTE_W-1:0]   sum_b_new;
   logic [IDX_W-1:0]    base_idx;
   logic [ADDR_W+IDX_W-1:0] addr_ext;

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      store         = 1'b0;
      done          = 1'b0;
      dropped       = 1'b0;
      len_full      = {rx_byte, bytes_left_ff[BYTE_W-1:0]};
      bytes_dec     = bytes_left_ff - 1'b1;

      case (phase_ff)
         ubxr_pkg::PH_HUNT: begin
            if (rx_byte == ubxr_pkg::SYNC_CHAR_1) begin
               phase_in = ubxr_pkg::PH_SYNC;
            end
         end
         ubxr_pkg::PH_SYNC: begin
            // a bad second sync byte is not retried as a first one
            phase_in = (rx_byte == ubxr_pkg::SYNC_CHAR_2) ?
                       ubxr_pkg::PH_CLASS : ubxr_pkg::PH_HUNT;
         end
         ubxr_pkg::PH_CLASS: begin
            phase_in = ubxr_pkg::PH_ID;
            store    = 1'b1;
         end
         ubxr_pkg::PH_ID: begin
            phase_in = ubxr_pkg::PH_LEN_LO;
            store    = 1'b1;
         end
         ubxr_pkg::PH_LEN_LO: begin
            bytes_left_in = {{(LEN_W-BYTE_W){1'b0}}, rx_byte};
            phase_in      = ubxr_pkg::PH_LEN_HI;
            store         = 1'b1;
         end
         ubxr_pkg::PH_LEN_HI: begin
            bytes_left_in = len_full;
            if (len_full > LEN_W'(BUFFER_LEN)) begin
               // oversize: high length byte neither summed nor written
               phase_in = ubxr_pkg::PH_HUNT;
               dropped  = 1'b1;
            end else begin
               phase_in = (len_full == '0) ? ubxr_pkg::PH_CK_A : ubxr_pkg::PH_PAYLOAD;
               store    = 1'b1;
            end
         end
         ubxr_pkg::PH_PAYLOAD: begin
            bytes_left_in = bytes_dec;
            if (bytes_dec == '0) begin
               phase_in = ubxr_pkg::PH_CK_A;
            end
            store = 1'b1;
         end
         ubxr_pkg::PH_CK_A: begin
            if (rx_byte == sum_a_ff) begin
               phase_in = ubxr_pkg::PH_CK_B;
            end else begin
               phase_in = ubxr_pkg::PH_HUNT;
               dropped  = 1'b1;
            end
         end
         ubxr_pkg::PH_CK_B: begin
            phase_in = ubxr_pkg::PH_HUNT;
            done     = (rx_byte == sum_b_ff);
            dropped  = (rx_byte != sum_b_ff);
         end
         default: begin
            phase_in = ubxr_pkg::PH_HUNT;
         end
      endcase

      // class byte restarts sums and buffer position
      base_a   = (phase_ff == ubxr_pkg::PH_CLASS) ? '0 : sum_a_ff;
      base_b   = (phase_ff == ubxr_pkg::PH_CLASS) ? '0 : sum_b_ff;
      base_idx = (phase_ff == ubxr_pkg::PH_CLASS) ? '0 : write_index_ff;

      sum_a_new = base_a + rx_byte;
      sum_b_new = base_b + sum_a_new;
      wr_en     = store && (base_idx < IDX_W'(BUFFER_LEN));

      sum_a_in       = store ? sum_a_new : sum_a_ff;
      sum_b_in       = store ? sum_b_new : sum_b_ff;
      write_index_in = wr_en ? base_idx + 1'b1 : write_index_ff;

      addr_ext = {{ADDR_W{1'b0}}, base_idx};

      result.wr_en         = wr_en;
      result.wr_addr       = wr_en ? addr_ext[ADDR_W-1:0] : '0;
      result.wr_data       = wr_en ? rx_byte : '0;
      result.frame_done    = done;
      result.frame_dropped = dropped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ubxr_pkg::PH_HUNT;
         bytes_left_ff  <= '0;
         sum_a_ff       <= '0;
         sum_b_ff       <= '0;
         write_index_ff <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         sum_a_ff       <= sum_a_in;
         sum_b_ff       <= sum_b_in;
         write_index_ff <= write_index_in;
      end
   end

   `UBX_ASSERT_NEVER(a_done_and_drop, result.frame_done && result.frame_dropped, "done and dropped together")
   `UBX_ASSERT(a_index_bound, write_index_ff <= IDX_W'(BUFFER_LEN), "write index beyond buffer")
   `UBX_ASSERT(a_payload_count, (phase_ff == ubxr_pkg::PH_PAYLOAD) |-> (bytes_left_ff != '0), "payload phase with no bytes left")
   `UBX_ASSERT(a_ck_b_ends, (advance && phase_ff == ubxr_pkg::PH_CK_B) |=> (phase_ff == ubxr_pkg::PH_HUNT), "frame end did not return to hunting")

endmodule

[sv/ubxr_out_stage.sv]
// two-entry result buffer: output register plus skid register
// depends on ubxr_pkg
module ubxr_out_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  ubxr_pkg::rsp_payload_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output ubxr_pkg::rsp_payload_type out_data
);

   logic                      main_valid_ff;
   logic                      skid_valid_ff;
   ubxr_pkg::rsp_payload_type main_data_ff;
   ubxr_pkg::rsp_payload_type skid_data_ff;
   logic                      in_fire;
   logic                      main_load;

   assign in_ready  = !skid_valid_ff;
   assign in_fire   = in_valid && in_ready;
   assign main_load = !main_valid_ff || out_ready;
   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (main_load) begin
         main_valid_ff <= skid_valid_ff || in_fire;
         skid_valid_ff <= 1'b0;
      end else if (in_fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (main_load) begin
         main_data_ff <= skid_valid_ff ? skid_data_ff : in_data;
      end
      if (!main_load && in_fire) begin
         skid_data_ff <= in_data;
      end
   end

endmodule

[sv/ubx_frame_receiver.sv]
// top level of the ubx frame receiver
// depends on ubxr_pkg, ubxr_stream_if, ubxr_parser and ubxr_out_stage
//
// usage
// - req_bus carries one serial byte per beat (rx_byte); rsp_bus returns one
//   result beat for every request beat, in order
// - a result tells whether the byte goes to the message buffer (wr_en,
//   wr_addr, wr_data) and flags frame_done or frame_dropped at frame end
// - the parser hunts for the two sync bytes, then buffers class, id, length
//   and payload from address 0 and checks the two fletcher-8 bytes
// - each result is registered before rsp_bus, via the skid entry on a stall
// - throughput: one byte per cycle while req_bus.ready is high; parse state
//   updates in the cycle it is taken, so back to back beats need no gaps
// - stall: a two-entry output buffer takes one more beat while a result
//   waits; req_bus.ready falls only when both entries are full
// - reset: synchronous; clears the parse state to hunting, the sums and
//   write index to zero and empties the output buffer
// - BUFFER_LEN sets the buffer size; longer frames are dropped and writes at
//   or beyond it are suppressed
module ubx_frame_receiver #(
   parameter int unsigned BUFFER_LEN = ubxr_pkg::BUFFER_LEN_DEF
) (
   input logic        clock,
   input logic        reset,
   ubxr_req_if.sink   req_bus,
   ubxr_rsp_if.source rsp_bus
);

   logic                      req_fire;
   ubxr_pkg::rsp_payload_type step_result;
   ubxr_pkg::rsp_payload_type rsp_data;

   // parse state advances only on an accepted beat
   assign req_fire = req_bus.valid && req_bus.ready;

   ubxr_parser #(
      .BUFFER_LEN (BUFFER_LEN)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .advance (req_fire),
      .rx_byte (req_bus.rx_byte),
      .result  (step_result)
   );

   // output register with skid entry
   ubxr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_data   (step_result),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_data)
   );

   // unpack result onto the response channel
   assign rsp_bus.wr_en         = rsp_data.wr_en;
   assign rsp_bus.wr_addr       = rsp_data.wr_addr;
   assign rsp_bus.wr_data       = rsp_data.wr_data;
   assign rsp_bus.frame_done    = rsp_data.frame_done;
   assign rsp_bus.frame_dropped = rsp_data.frame_dropped;

endmodule

[verif/tb.sv]
// self-checking testbench for ubx_frame_receiver: serial bytes in, buffer writes out
// depends on ubxr_pkg, ubxr_stream_if and the ubx_frame_receiver rtl
// a local parser model predicts every result beat; the monitor compares field by field
module tb;
   import ubxr_pkg::*;

   localparam int unsigned BUF_LEN      = BUFFER_LEN_DEF;
   localparam int          RANDOM_BYTES = 1100;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          HOLD_CYCLES  = 48;

   typedef enum logic [1:0] {
      FLOW_FREE,
      FLOW_SRC_GAPS,
      FLOW_SINK_STALLS,
      FLOW_BOTH
   } flow_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ubxr_req_if req_bus ();
   ubxr_rsp_if rsp_bus ();

   ubx_frame_receiver #(
      .BUFFER_LEN(BUF_LEN)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   // serial bytes still to be sent, and buffer writes the parser model expects back
   logic [BYTE_W-1:0] serial_bytes[$];
   rsp_payload_type   buffer_writes_due[$];

   flow_type flow        = FLOW_FREE;
   logic     hold_off    = 1'b0;
   int       beats_in    = 0;
   int       beats_out   = 0;
   int       mismatches  = 0;
   int       cycle_count = 0;

   // parser model state: phase, payload bytes still to come, fletcher sums, buffer position
   phase_type         frame_phase  = PH_HUNT;
   logic [LEN_W-1:0]  payload_left = '0;
   logic [BYTE_W-1:0] fletcher_a   = '0;
   logic [BYTE_W-1:0] fletcher_b   = '0;
   int unsigned       buf_pos      = 0;

   // known levels on every input before the first edge
   initial begin
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      rsp_bus.ready   = 1'b0;
   end

   // ------------------------------------------------------------------
   // parser model: one serial byte in, one result beat out
   // ------------------------------------------------------------------
   function automatic rsp_payload_type parse_serial_byte(input logic [BYTE_W-1:0] b);
      rsp_payload_type r;
      bit              keep;
      r    = '0;
      keep = 1'b0;
      case (frame_phase)
         PH_HUNT: begin
            if (b == SYNC_CHAR_1) frame_phase = PH_SYNC;
         end
         // a wrong second sync byte is not taken as a fresh first one
         PH_SYNC: begin
            frame_phase = (b == SYNC_CHAR_2) ? PH_CLASS : PH_HUNT;
         end
         // class byte restarts the sums and the buffer position
         PH_CLASS: begin
            fletcher_a  = '0;
            fletcher_b  = '0;
            buf_pos     = 0;
            frame_phase = PH_ID;
            keep        = 1'b1;
         end
         PH_ID: begin
            frame_phase = PH_LEN_LO;
            keep        = 1'b1;
         end
         PH_LEN_LO: begin
            payload_left = {8'h00, b};
            frame_phase  = PH_LEN_HI;
            keep         = 1'b1;
         end
         // oversize length: high byte neither written nor summed, frame dropped
         PH_LEN_HI: begin
            payload_left = {b, payload_left[7:0]};
            if (payload_left > BUF_LEN) begin
               frame_phase     = PH_HUNT;
               r.frame_dropped = 1'b1;
            end else begin
               frame_phase = (payload_left == 0) ? PH_CK_A : PH_PAYLOAD;
               keep        = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            payload_left = payload_left - 1'b1;
            if (payload_left == 0) frame_phase = PH_CK_A;
            keep = 1'b1;
         end
         // check bytes are compared only, never written or summed
         PH_CK_A: begin
            if (fletcher_a == b) begin
               frame_phase = PH_CK_B;
            end else begin
               frame_phase     = PH_HUNT;
               r.frame_dropped = 1'b1;
            end
         end
         PH_CK_B: begin
            frame_phase = PH_HUNT;
            if (fletcher_b == b) r.frame_done = 1'b1;
            else r.frame_dropped = 1'b1;
         end
         default: begin
            frame_phase = PH_HUNT;
         end
      endcase
      // positions past the buffer are summed but not written, and the position saturates
      if (keep) begin
         fletcher_a = fletcher_a + b;
         fletcher_b = fletcher_b + fletcher_a;
         if (buf_pos < BUF_LEN) begin
            r.wr_en   = 1'b1;
            r.wr_addr = buf_pos[ADDR_W-1:0];
            r.wr_data = b;
            buf_pos++;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   // whole frame with random payload; oversize lengths stop after the length bytes
   task automatic queue_frame(input logic [BYTE_W-1:0] cls, input logic [BYTE_W-1:0] msg_id,
                              input logic [LEN_W-1:0] len, input bit bad_a, input bit bad_b);
      logic [BYTE_W-1:0] ck_a;
      logic [BYTE_W-1:0] ck_b;
      logic [BYTE_W-1:0] b;
      ck_a = '0;
      ck_b = '0;
      serial_bytes.push_back(SYNC_CHAR_1);
      serial_bytes.push_back(SYNC_CHAR_2);
      for (int i = 0; i < 4 + int'(len); i++) begin
         case (i)
            0:       b = cls;
            1:       b = msg_id;
            2:       b = len[7:0];
            3:       b = len[15:8];
            default: b = 8'($urandom);
         endcase
         serial_bytes.push_back(b);
         if (i == 3 && len > BUF_LEN) return;
         ck_a = ck_a + b;
         ck_b = ck_b + ck_a;
      end
      serial_bytes.push_back(bad_a ? ck_a ^ 8'($urandom_range(1, 255)) : ck_a);
      serial_bytes.push_back(bad_b ? ck_b ^ 8'($urandom_range(1, 255)) : ck_b);
   endtask

   function automatic bit idle_now(input bit sink_side);
      int unsigned pct;
      case (flow)
         FLOW_FREE:        pct = 0;
         FLOW_SRC_GAPS:    pct = sink_side ? 0 : 55;
         FLOW_SINK_STALLS: pct = sink_side ? 55 : 0;
         default:          pct = 14;
      endcase
      return $urandom_range(99) < pct;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at result beat %0d: %s", beats_out, what);
      mismatches++;
   endtask

   // ------------------------------------------------------------------
   // request driver: presents queued bytes, runs the model on each accepted beat
   // ------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic taken;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken) begin
            buffer_writes_due.push_back(parse_serial_byte(req_bus.rx_byte));
            beats_in <= beats_in + 1;
         end
         // only move on once the current beat has gone or nothing is offered
         if (taken || !req_bus.valid) begin
            if (serial_bytes.size() != 0 && !idle_now(1'b0)) begin
               req_bus.rx_byte <= serial_bytes.pop_front();
               req_bus.valid   <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result monitor: every accepted beat against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (buffer_writes_due.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = buffer_writes_due.pop_front();
               if (rsp_bus.wr_en !== want.wr_en)
                  report_mismatch($sformatf("wr_en %b, expected %b", rsp_bus.wr_en, want.wr_en));
               if (rsp_bus.wr_addr !== want.wr_addr)
                  report_mismatch($sformatf("wr_addr %0d, expected %0d",
                                            rsp_bus.wr_addr, want.wr_addr));
               if (rsp_bus.wr_data !== want.wr_data)
                  report_mismatch($sformatf("wr_data %h, expected %h",
                                            rsp_bus.wr_data, want.wr_data));
               if (rsp_bus.frame_done !== want.frame_done)
                  report_mismatch($sformatf("frame_done %b, expected %b",
                                            rsp_bus.frame_done, want.frame_done));
               if (rsp_bus.frame_dropped !== want.frame_dropped)
                  report_mismatch($sformatf("frame_dropped %b, expected %b",
                                            rsp_bus.frame_dropped, want.frame_dropped));
            end
            beats_out++;
         end
         rsp_bus.ready <= !hold_off && !idle_now(1'b1);
      end
   end

   // watchdog
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // long receiver hold-off early on, so the output buffer fills and req ready drops
   initial begin : long_hold
      while (beats_in < 60) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // ------------------------------------------------------------------
   // stimulus, flow phases and end of run
   // ------------------------------------------------------------------
   initial begin : main
      int          total;
      int          noise_bytes;
      int unsigned pick;
      int unsigned n;
      bit          big_sent;
      logic [7:0]  b;

      // directed: bad second sync byte, repeated first sync byte
      serial_bytes.push_back(SYNC_CHAR_1);
      serial_bytes.push_back(8'h00);
      serial_bytes.push_back(SYNC_CHAR_1);
      serial_bytes.push_back(SYNC_CHAR_1);
      serial_bytes.push_back(SYNC_CHAR_2);
      // zero-length payload goes straight to the check bytes
      queue_frame(8'h00, 8'hFF, 16'd0, 1'b0, 1'b0);
      // one past the buffer size, then the largest length
      queue_frame(8'hFF, 8'h00, 16'(BUF_LEN + 1), 1'b0, 1'b0);
      queue_frame(8'h01, 8'h02, 16'hFFFF, 1'b0, 1'b0);

      // random part: mostly well-formed short frames, some noise and broken ones
      noise_bytes = 0;
      big_sent    = 1'b0;
      while (serial_bytes.size() - noise_bytes < RANDOM_BYTES) begin
         pick = $urandom_range(99);
         if (!big_sent && serial_bytes.size() > 300) begin
            // a single full-size frame runs the buffer position past its end
            queue_frame(8'($urandom), 8'($urandom), 16'(BUF_LEN), 1'b0, 1'b0);
            big_sent = 1'b1;
         end else if (pick < 8) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) serial_bytes.push_back(8'($urandom));
            noise_bytes += n;
         end else if (pick < 14) begin
            b = 8'($urandom);
            if (b == SYNC_CHAR_2) b = b + 1'b1;
            serial_bytes.push_back(SYNC_CHAR_1);
            serial_bytes.push_back(b);
         end else if (pick < 22) begin
            queue_frame(8'($urandom), 8'($urandom),
                        16'($urandom_range(BUF_LEN + 1, 65535)), 1'b0, 1'b0);
         end else begin
            n = (pick < 26) ? $urandom_range(13, 80) : $urandom_range(0, 12);
            queue_frame(8'($urandom), 8'($urandom), 16'(n),
                        pick >= 90 && pick < 95, pick >= 95);
         end
      end
      total = serial_bytes.size();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // cycle through the flow phases twice, stepping on accepted beats
      for (int s = 0; s < 8; s++) begin
         flow <= flow_type'(s % 4);
         @(posedge clock);
         while (beats_in < (s + 1) * total / 8) @(posedge clock);
      end
      flow <= FLOW_FREE;

      // drain, then keep clocking to catch any stray beat
      while (serial_bytes.size() != 0 || req_bus.valid || buffer_writes_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
